// ===== hw/rtl/cnc_pkg.sv =====
`default_nettype none

package cnc_pkg;

   localparam int POS_W      = 24;
   localparam int MAG_W      = 24;
   localparam int LEN_W      = 23;
   localparam int CUT_W      = 50;
   localparam int SQ_W       = 48;
   localparam int CNT_W      = 11;
   localparam int LBL_W      = 3;
   localparam int OFS_W      = 16;
   localparam int ID_W       = 32;
   localparam int STS_W      = 2;
   localparam int REQ_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 50;
   localparam int NUM_AXES   = 3;
   localparam int NUM_LABELS = 5;
   localparam int DIV_STEPS  = MAG_W;

   localparam logic [CNT_W-1:0] COUNT_MAX        = 11'h7FF;
   localparam logic [LBL_W-1:0] LAST_EXACT_LABEL = 3'd3;
   localparam logic [LBL_W-1:0] OVERFLOW_LABEL   = 3'd4;
   localparam logic [OFS_W-1:0] OFFSET_MAX       = 16'hFFFF;

   typedef enum logic [REQ_W-1:0] {
      REQ_CLEAR = 2'd0,
      REQ_LOAD  = 2'd1,
      REQ_QUERY = 2'd2
   } req_code_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK          = 2'd0,
      STS_CUTOFF_ZERO = 2'd1,
      STS_LEN_ZERO    = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CUTOFF = 3'd0,
      CSR_MASK   = 3'd1,
      CSR_LEN_X  = 3'd2,
      CSR_LEN_Y  = 3'd3,
      CSR_LEN_Z  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [CUT_W-1:0]                 cutoff;
      logic [NUM_AXES-1:0]              mask;
      logic [NUM_AXES-1:0][LEN_W-1:0]   len;
   } cfg_type;

   typedef struct packed {
      logic                             vld;
      logic [NUM_AXES-1:0][LEN_W-1:0]   rem;
      logic [NUM_AXES-1:0][MAG_W-1:0]   num;
      logic [NUM_AXES-1:0][MAG_W-1:0]   quo;
      logic [NUM_AXES-1:0][MAG_W-1:0]   mag;
   } div_stage_type;

   typedef struct packed {
      logic busy;
      logic hit_vld;
      logic hit;
   } dist_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/cnc_channels.sv =====
`default_nettype none

interface cnc_req_if;
   import cnc_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [REQ_W-1:0]        req_type;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;
   logic signed [POS_W-1:0] pos_z;
   logic [ID_W-1:0]         atom_id;

   modport source (output valid, req_type, pos_x, pos_y, pos_z, atom_id, input ready);
   modport sink   (input valid, req_type, pos_x, pos_y, pos_z, atom_id, output ready);
endinterface

interface cnc_rsp_if;
   import cnc_pkg::*;

   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] neighbor_count;
   logic [LBL_W-1:0] label;
   logic [OFS_W-1:0] group_offset;
   logic [ID_W-1:0]  atom_id_out;
   logic [STS_W-1:0] status;

   modport source (output valid, neighbor_count, label, group_offset, atom_id_out, status,
                   input ready);
   modport sink   (input valid, neighbor_count, label, group_offset, atom_id_out, status,
                   output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cnc_ram.sv =====
`default_nettype none

module cnc_ram #(
   parameter int  WIDTH  = 72,
   parameter int  DEPTH  = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/cnc_div_cell.sv =====
`default_nettype none

// one restoring step per axis: one quotient bit of |d| / len
module cnc_div_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cnc_pkg::cfg_type       cfg,
   input  wire cnc_pkg::div_stage_type prev_stage,
   output      cnc_pkg::div_stage_type next_stage
);
   import cnc_pkg::*;

   div_stage_type stage_ff;
   div_stage_type stage_in;

   always_comb begin
      logic [MAG_W-1:0] trial;
      stage_in     = prev_stage;
      stage_in.vld = prev_stage.vld && !reset;
      for (int a = 0; a < NUM_AXES; a++) begin
         trial = {prev_stage.rem[a], prev_stage.num[a][MAG_W-1]};
         if (trial >= MAG_W'(cfg.len[a])) begin
            stage_in.rem[a] = LEN_W'(trial - MAG_W'(cfg.len[a]));
            stage_in.quo[a] = {prev_stage.quo[a][MAG_W-2:0], 1'b1};
         end else begin
            stage_in.rem[a] = trial[LEN_W-1:0];
            stage_in.quo[a] = {prev_stage.quo[a][MAG_W-2:0], 1'b0};
         end
         stage_in.num[a] = {prev_stage.num[a][MAG_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign next_stage = stage_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/cnc_dist.sv =====
`default_nettype none

// round-to-nearest-even fold, squares, sum and cutoff compare
module cnc_dist (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cnc_pkg::cfg_type       cfg,
   input  wire cnc_pkg::div_stage_type last_stage,
   output      cnc_pkg::dist_status_type dist_status
);
   import cnc_pkg::*;

   logic                            a_vld_ff;
   logic [NUM_AXES-1:0][MAG_W-1:0]  abs_ff;
   logic [NUM_AXES-1:0][MAG_W-1:0]  abs_in;
   logic                            b_vld_ff;
   logic [NUM_AXES-1:0][SQ_W-1:0]   sq_ff;
   logic                            c_vld_ff;
   logic                            hit_ff;
   logic [CUT_W-1:0]                sum;

   always_comb begin
      logic [MAG_W-1:0] twice;
      logic [MAG_W-1:0] len_ext;
      logic             up;
      for (int a = 0; a < NUM_AXES; a++) begin
         twice   = {last_stage.rem[a], 1'b0};
         len_ext = MAG_W'(cfg.len[a]);
         up      = (twice > len_ext) || ((twice == len_ext) && last_stage.quo[a][0]);
         if (!cfg.mask[a]) begin
            abs_in[a] = last_stage.mag[a];
         end else if (up) begin
            abs_in[a] = MAG_W'(cfg.len[a] - last_stage.rem[a]);
         end else begin
            abs_in[a] = MAG_W'(last_stage.rem[a]);
         end
      end
   end

   assign sum = CUT_W'(sq_ff[0]) + CUT_W'(sq_ff[1]) + CUT_W'(sq_ff[2]);

   always_ff @(posedge clock) begin
      abs_ff <= abs_in;
      for (int a = 0; a < NUM_AXES; a++) begin
         sq_ff[a] <= abs_ff[a] * abs_ff[a];
      end
      hit_ff <= (sum <= cfg.cutoff);
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= last_stage.vld;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
      end
   end

   assign dist_status.busy    = last_stage.vld | a_vld_ff | b_vld_ff | c_vld_ff;
   assign dist_status.hit_vld = c_vld_ff;
   assign dist_status.hit     = hit_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/cutoff_neighbor_counter.sv =====
// Cutoff neighbor counter.
// Request channel (req_chan): req_type 0 clears the hydrogen store and the five
// label counters, 1 appends a hydrogen position (dropped when the store is full),
// 2 queries an oxygen position; only queries produce a response on rsp_chan.
// Configuration (csr_*) is written one register per cycle; the user must write it
// only while the block is idle, which the block itself does not enforce. Clear and
// load requests complete on acceptance and leave the block idle. A query reads the
// position RAM one hydrogen per cycle; each read flows through a 24-cell divider
// chain (minimum image), a fold stage, a square stage and a compare stage.
// A query with bad configuration skips the scan and answers with a status.
// One request is worked on at a time; a clear or load is accepted while an
// earlier response still waits in the output register.
// When the receiver stalls, the response is held; a following query completes
// its scan and then waits until the output register frees.
// Reset empties the store, zeroes the label counters and all configuration
// registers; store contents are undefined until loaded.
`default_nettype none

module cutoff_neighbor_counter #(
   parameter int              MAX_HYDROGEN = 1024,
   parameter longint unsigned MAX_GROUP    = 65535
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   cnc_req_if.sink                             req_chan,
   cnc_rsp_if.source                           rsp_chan,
   input  wire logic                           csr_wr_en,
   input  wire logic [cnc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [cnc_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import cnc_pkg::*;

   localparam int ADDR_W = (MAX_HYDROGEN > 1) ? $clog2(MAX_HYDROGEN) : 1;
   localparam int HCNT_W = $clog2(MAX_HYDROGEN + 1);
   localparam int RAM_W  = NUM_AXES * POS_W;
   localparam logic [OFS_W-1:0] GROUP_LIMIT =
      (MAX_GROUP > 64'(OFFSET_MAX)) ? OFFSET_MAX : OFS_W'(MAX_GROUP);

   state_type                      state_ff, state_in;
   cfg_type                        cfg_ff;
   logic [HCNT_W-1:0]              hcount_ff;
   logic [HCNT_W-1:0]              idx_ff;
   logic [CNT_W-1:0]               count_ff;
   logic [OFS_W-1:0]               lc_ff [NUM_LABELS];
   logic [NUM_AXES-1:0][POS_W-1:0] qpos_ff;
   logic [ID_W-1:0]                id_ff;
   status_type                     status_ff, status_calc;
   logic                           vld_rd_ff;
   logic                           rsp_vld_ff;
   logic [CNT_W-1:0]               rsp_count_ff;
   logic [LBL_W-1:0]               rsp_label_ff;
   logic [OFS_W-1:0]               rsp_offset_ff;
   logic [ID_W-1:0]                rsp_id_ff;
   logic [STS_W-1:0]               rsp_status_ff;

   logic                           req_acc;
   logic                           is_query, is_load, is_clear;
   logic                           scan_last;
   logic                           rd_en;
   logic                           resp_load;
   logic                           busy;
   logic                           chain_busy;
   logic [LBL_W-1:0]               label_calc;
   logic [RAM_W-1:0]               wr_data;
   logic [RAM_W-1:0]               rd_data;
   div_stage_type                  chain [DIV_STEPS+1];
   dist_status_type                dist_status;

   // ---------------- request decode and status
   assign req_acc  = req_chan.valid & req_chan.ready;
   assign is_query = req_chan.req_type == REQ_QUERY;
   assign is_load  = req_chan.req_type == REQ_LOAD;
   assign is_clear = req_chan.req_type == REQ_CLEAR;

   always_comb begin
      priority if (cfg_ff.cutoff == '0) begin
         status_calc = STS_CUTOFF_ZERO;
      end else if ((cfg_ff.mask[0] && cfg_ff.len[0] == '0) ||
                   (cfg_ff.mask[1] && cfg_ff.len[1] == '0) ||
                   (cfg_ff.mask[2] && cfg_ff.len[2] == '0)) begin
         status_calc = STS_LEN_ZERO;
      end else begin
         status_calc = STS_OK;
      end
   end

   assign scan_last = (idx_ff + HCNT_W'(1)) == hcount_ff;
   assign busy      = vld_rd_ff | chain_busy | dist_status.busy;

   // ---------------- control
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && is_query) begin
               if (status_calc != STS_OK) begin
                  state_in = ST_RESP;
               end else if (hcount_ff == '0) begin
                  state_in = ST_DRAIN;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!busy) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (resp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready = 1'b0;
      rd_en          = 1'b0;
      resp_load      = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_chan.ready = 1'b1;
         ST_SCAN:  rd_en = 1'b1;
         ST_DRAIN: ;
         ST_RESP:  resp_load = !rsp_vld_ff || rsp_chan.ready;
         default:  ;
      endcase
   end

   // ---------------- position store
   assign wr_data = {req_chan.pos_z, req_chan.pos_y, req_chan.pos_x};

   cnc_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_HYDROGEN)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_acc && is_load && (hcount_ff < HCNT_W'(MAX_HYDROGEN))),
      .wr_addr (hcount_ff[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // ---------------- divider chain
   always_comb begin
      logic signed [POS_W:0] diff;
      chain[0]     = '0;
      chain[0].vld = vld_rd_ff;
      for (int a = 0; a < NUM_AXES; a++) begin
         diff = {rd_data[a*POS_W + POS_W - 1], rd_data[a*POS_W +: POS_W]} -
                {qpos_ff[a][POS_W-1], qpos_ff[a]};
         chain[0].num[a] = diff[POS_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];
         chain[0].mag[a] = chain[0].num[a];
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
      cnc_div_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cfg        (cfg_ff),
         .prev_stage (chain[k]),
         .next_stage (chain[k+1])
      );
   end

   always_comb begin
      chain_busy = 1'b0;
      for (int k = 1; k <= DIV_STEPS; k++) begin
         chain_busy = chain_busy | chain[k].vld;
      end
   end

   cnc_dist u_dist (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .last_stage  (chain[DIV_STEPS]),
      .dist_status (dist_status)
   );

   // ---------------- result
   assign label_calc = (count_ff <= CNT_W'(LAST_EXACT_LABEL)) ? count_ff[LBL_W-1:0]
                                                               : OVERFLOW_LABEL;

   always_ff @(posedge clock) begin
      if (req_acc && is_query) begin
         qpos_ff   <= {req_chan.pos_z, req_chan.pos_y, req_chan.pos_x};
         id_ff     <= req_chan.atom_id;
         status_ff <= status_calc;
      end
      if (resp_load) begin
         rsp_id_ff     <= id_ff;
         rsp_status_ff <= status_ff;
         if (status_ff == STS_OK) begin
            rsp_count_ff  <= count_ff;
            rsp_label_ff  <= label_calc;
            rsp_offset_ff <= lc_ff[label_calc];
         end else begin
            rsp_count_ff  <= '0;
            rsp_label_ff  <= '0;
            rsp_offset_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cfg_ff     <= '0;
         hcount_ff  <= '0;
         idx_ff     <= '0;
         count_ff   <= '0;
         vld_rd_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         for (int l = 0; l < NUM_LABELS; l++) begin
            lc_ff[l] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         vld_rd_ff <= rd_en;

         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_CUTOFF: cfg_ff.cutoff <= csr_wr_data[CUT_W-1:0];
               CSR_MASK:   cfg_ff.mask   <= csr_wr_data[NUM_AXES-1:0];
               CSR_LEN_X:  cfg_ff.len[0] <= csr_wr_data[LEN_W-1:0];
               CSR_LEN_Y:  cfg_ff.len[1] <= csr_wr_data[LEN_W-1:0];
               CSR_LEN_Z:  cfg_ff.len[2] <= csr_wr_data[LEN_W-1:0];
               default: ;
            endcase
         end

         if (req_acc && is_clear) begin
            hcount_ff <= '0;
            for (int l = 0; l < NUM_LABELS; l++) begin
               lc_ff[l] <= '0;
            end
         end else if (req_acc && is_load && (hcount_ff < HCNT_W'(MAX_HYDROGEN))) begin
            hcount_ff <= hcount_ff + HCNT_W'(1);
         end

         if (req_acc && is_query) begin
            idx_ff <= '0;
         end else if (rd_en) begin
            idx_ff <= idx_ff + HCNT_W'(1);
         end

         if (req_acc && is_query) begin
            count_ff <= '0;
         end else if (dist_status.hit_vld && dist_status.hit && (count_ff < COUNT_MAX)) begin
            count_ff <= count_ff + CNT_W'(1);
         end

         if (resp_load && (status_ff == STS_OK) && (lc_ff[label_calc] < GROUP_LIMIT)) begin
            lc_ff[label_calc] <= lc_ff[label_calc] + OFS_W'(1);
         end

         if (resp_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid          = rsp_vld_ff;
   assign rsp_chan.neighbor_count = rsp_count_ff;
   assign rsp_chan.label          = rsp_label_ff;
   assign rsp_chan.group_offset   = rsp_offset_ff;
   assign rsp_chan.atom_id_out    = rsp_id_ff;
   assign rsp_chan.status         = rsp_status_ff;

   // ---------------- assertions
   a_hcount_bound: assert property (@(posedge clock) disable iff (reset)
      hcount_ff <= HCNT_W'(MAX_HYDROGEN))
      else $error("hydrogen count above store depth");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (idx_ff < hcount_ff))
      else $error("scan reads beyond loaded entries");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !busy)
      else $error("pipeline busy while idle");

   a_resp_shown: assert property (@(posedge clock) disable iff (reset)
      resp_load |=> rsp_vld_ff)
      else $error("response lost at output register");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import cnc_pkg::*;

   localparam int          HYD_DEPTH   = 1024;
   localparam int unsigned GROUP_LIMIT = 65535;
   localparam int          SETTLE      = 40;
   localparam int          WATCHDOG    = 20000;
   localparam int          LONG_HOLD   = 3000;
   localparam int          PHASES      = 9;
   localparam int          PHASE_ITEMS = 60;

   typedef struct {
      logic [CNT_W-1:0] count;
      logic [LBL_W-1:0] label;
      logic [OFS_W-1:0] offset;
      logic [ID_W-1:0]  id;
      logic [STS_W-1:0] status;
   } neighbor_result_type;

   class neighbor_scoreboard;
      logic signed [POS_W-1:0] hx[HYD_DEPTH];
      logic signed [POS_W-1:0] hy[HYD_DEPTH];
      logic signed [POS_W-1:0] hz[HYD_DEPTH];
      int unsigned             hyd_count;
      int unsigned             group_ctr[NUM_LABELS];
      logic [CUT_W-1:0]        cutoff;
      logic [NUM_AXES-1:0]     mask;
      logic [LEN_W-1:0]        cell_len[NUM_AXES];
      neighbor_result_type     expected_q[$];
      int                      errors;
      int                      queries;
      int                      loads;

      function new();
         hyd_count = 0;
         foreach (group_ctr[i]) group_ctr[i] = 0;
         cutoff = '0;
         mask = '0;
         foreach (cell_len[i]) cell_len[i] = '0;
         errors = 0;
         queries = 0;
         loads = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            CSR_CUTOFF: cutoff = v[CUT_W-1:0];
            CSR_MASK:   mask = v[NUM_AXES-1:0];
            CSR_LEN_X:  cell_len[0] = v[LEN_W-1:0];
            CSR_LEN_Y:  cell_len[1] = v[LEN_W-1:0];
            CSR_LEN_Z:  cell_len[2] = v[LEN_W-1:0];
            default: ;
         endcase
      endfunction

      // minimum image, quotient rounded to nearest with ties to even
      function longint min_image(longint d, longint unsigned len, bit on);
         longint unsigned mag, q, r;
         longint          m;
         if (!on || len == 0) return d;
         mag = (d < 0) ? -d : d;
         q = mag / len;
         r = mag % len;
         if (2 * r > len || (2 * r == len && q[0])) q++;
         m = q * len;
         return (d < 0) ? d + m : d - m;
      endfunction

      function void note_request(logic [REQ_W-1:0] rt, logic signed [POS_W-1:0] px,
                                 logic signed [POS_W-1:0] py, logic signed [POS_W-1:0] pz,
                                 logic [ID_W-1:0] id);
         neighbor_result_type res;
         longint              dx, dy, dz;
         longint unsigned     d2;
         int unsigned         cnt, lbl;
         if (rt == REQ_CLEAR) begin
            hyd_count = 0;
            foreach (group_ctr[i]) group_ctr[i] = 0;
         end else if (rt == REQ_LOAD) begin
            loads++;
            if (hyd_count < HYD_DEPTH) begin
               hx[hyd_count] = px;
               hy[hyd_count] = py;
               hz[hyd_count] = pz;
               hyd_count++;
            end
         end else if (rt == REQ_QUERY) begin
            queries++;
            res.count = '0;
            res.label = '0;
            res.offset = '0;
            res.id = id;
            res.status = STS_OK;
            if (cutoff == 0)
               res.status = STS_CUTOFF_ZERO;
            else if ((mask[0] && cell_len[0] == 0) || (mask[1] && cell_len[1] == 0) ||
                     (mask[2] && cell_len[2] == 0))
               res.status = STS_LEN_ZERO;
            if (res.status == STS_OK) begin
               cnt = 0;
               for (int i = 0; i < hyd_count; i++) begin
                  dx = min_image(longint'(hx[i]) - longint'(px), 64'(cell_len[0]), mask[0]);
                  dy = min_image(longint'(hy[i]) - longint'(py), 64'(cell_len[1]), mask[1]);
                  dz = min_image(longint'(hz[i]) - longint'(pz), 64'(cell_len[2]), mask[2]);
                  d2 = dx * dx + dy * dy + dz * dz;
                  if (d2 <= longint'(cutoff) && cnt < COUNT_MAX) cnt++;
               end
               lbl = (cnt <= LAST_EXACT_LABEL) ? cnt : OVERFLOW_LABEL;
               res.count = CNT_W'(cnt);
               res.label = LBL_W'(lbl);
               res.offset = OFS_W'(group_ctr[lbl]);
               if (group_ctr[lbl] < GROUP_LIMIT) group_ctr[lbl]++;
            end
            expected_q = {expected_q, res};
         end
      endfunction

      function void check_response(logic [CNT_W-1:0] cnt, logic [LBL_W-1:0] lbl,
                                   logic [OFS_W-1:0] ofs, logic [ID_W-1:0] id,
                                   logic [STS_W-1:0] sts);
         neighbor_result_type e;
         if (expected_q.size() == 0) begin
            $error("unexpected response: count %0d id %h", cnt, id);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (cnt !== e.count) begin
            $error("neighbor_count: expected %0d, actual %0d", e.count, cnt);
            errors++;
         end
         if (lbl !== e.label) begin
            $error("label: expected %0d, actual %0d", e.label, lbl);
            errors++;
         end
         if (ofs !== e.offset) begin
            $error("group_offset: expected %0d, actual %0d", e.offset, ofs);
            errors++;
         end
         if (id !== e.id) begin
            $error("atom_id_out: expected %h, actual %h", e.id, id);
            errors++;
         end
         if (sts !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, sts);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   cnc_req_if req_chan();
   cnc_rsp_if rsp_chan();

   cutoff_neighbor_counter dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   neighbor_scoreboard sb = new();
   bit quiet;
   bit hold_req;
   int idle_cycles;

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            sb.note_request(req_chan.req_type, req_chan.pos_x, req_chan.pos_y,
                            req_chan.pos_z, req_chan.atom_id);
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_response(rsp_chan.neighbor_count, rsp_chan.label,
                              rsp_chan.group_offset, rsp_chan.atom_id_out, rsp_chan.status);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_chan.ready <= 1'b0;
            hold_req = 0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(0, 4)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic send(logic [REQ_W-1:0] rt, logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                       logic [POS_W-1:0] pz, logic [ID_W-1:0] id);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.req_type <= rt;
      req_chan.pos_x <= px;
      req_chan.pos_y <= py;
      req_chan.pos_z <= pz;
      req_chan.atom_id <= id;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic configure(logic [CUT_W-1:0] cut, logic [NUM_AXES-1:0] msk,
                            logic [LEN_W-1:0] lx, logic [LEN_W-1:0] ly, logic [LEN_W-1:0] lz);
      logic [CSR_DATA_W-1:0] vals[5];
      csr_index_type         idx[5];
      vals = '{CSR_DATA_W'(cut), CSR_DATA_W'(msk), CSR_DATA_W'(lx), CSR_DATA_W'(ly),
               CSR_DATA_W'(lz)};
      idx = '{CSR_CUTOFF, CSR_MASK, CSR_LEN_X, CSR_LEN_Y, CSR_LEN_Z};
      for (int i = 0; i < 5; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= idx[i];
         csr_wr_data <= vals[i];
         sb.write_reg(idx[i], vals[i]);
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [POS_W-1:0] near(logic [POS_W-1:0] c, int unsigned spread);
      return c + POS_W'($urandom_range(0, 2 * spread) - spread);
   endfunction

   initial begin
      logic [POS_W-1:0]  cx, cy, cz, px, py, pz;
      int unsigned       spread, k, r;
      logic [CUT_W-1:0]  cut;
      logic [LEN_W-1:0]  lx, ly, lz;
      logic [NUM_AXES-1:0] msk;
      quiet = 0;
      hold_req = 0;
      idle_cycles = 0;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.req_type <= REQ_CLEAR;
      req_chan.pos_x <= '0;
      req_chan.pos_y <= '0;
      req_chan.pos_z <= '0;
      req_chan.atom_id <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_CUTOFF;
      csr_wr_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: invalid configurations, ties, extremes, ignored code
      send(REQ_QUERY, 24'h7FFFFF, 24'h800000, 24'h0, 32'hFFFFFFFF);
      settle();
      configure({CUT_W{1'b1}}, 3'b111, '0, '0, '0);
      send(REQ_QUERY, 24'h0, 24'h0, 24'h0, 32'h0);
      settle();
      configure(CUT_W'(64'd1 << 30), 3'b111, 23'd65536, 23'd65536, 23'h7FFFFF);
      send(REQ_LOAD, 24'h0, 24'h0, 24'h0, 32'h0);
      send(REQ_LOAD, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 32'hFFFFFFFF);
      send(REQ_QUERY, 24'd32768, 24'h0, 24'h0, 32'h1);
      send(REQ_QUERY, 24'd98304, 24'h0, 24'h0, 32'h2);
      send(REQ_QUERY, 24'h0, 24'd32769, 24'h0, 32'h3);
      send(REQ_QUERY, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 32'h4);
      send(2'd3, 24'h123456, 24'h0, 24'h0, 32'h5);
      send(REQ_QUERY, 24'h800000, 24'h7FFFFF, 24'h800000, 32'h6);
      send(REQ_CLEAR, 24'h0, 24'h0, 24'h0, 32'h0);
      send(REQ_QUERY, 24'h0, 24'h0, 24'h0, 32'hA5A5A5A5);
      settle();

      // wide random positions, plain then mixed periodic axes
      configure({CUT_W{1'b1}}, 3'b000, 23'd1, 23'd1, 23'd1);
      for (int i = 0; i < 10; i++)
         send(REQ_LOAD, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom), $urandom);
      send(REQ_QUERY, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom), $urandom);
      settle();
      configure(CUT_W'(64'd1 << 44), 3'b101, 23'h7FFFFF, 23'd0, 23'd4096);
      send(REQ_QUERY, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom), $urandom);
      send(REQ_CLEAR, 24'h0, 24'h0, 24'h0, 32'h0);
      settle();

      for (int p = 0; p < PHASES; p++) begin
         quiet = (p == PHASES - 1);
         spread = 1 << $urandom_range(10, 18);
         r = spread * $urandom_range(1, 3);
         cut = CUT_W'(longint'(r) * longint'(r));
         msk = NUM_AXES'($urandom_range(0, 7));
         lx = LEN_W'($urandom_range(1, 23'h7FFFFF));
         ly = LEN_W'(spread * $urandom_range(1, 8));
         lz = LEN_W'($urandom_range(spread, 8 * spread));
         case (p)
            0: configure({CUT_W{1'b1}}, 3'b000, lx, ly, lz);
            1: configure(CUT_W'(1), 3'b111, 23'd1, 23'd1, 23'd1);
            2: configure(cut, 3'b111, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF);
            default: configure(cut, msk, lx, ly, lz);
         endcase
         cx = POS_W'($urandom);
         cy = POS_W'($urandom);
         cz = POS_W'($urandom);
         send(REQ_CLEAR, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom), $urandom);
         if (p == 4) hold_req = 1;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            k = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) begin
               px = POS_W'($urandom);
               py = POS_W'($urandom);
               pz = POS_W'($urandom);
            end else begin
               px = near(cx, spread);
               py = near(cy, spread);
               pz = near(cz, spread);
            end
            if (k < 5)
               send(REQ_CLEAR, px, py, pz, $urandom);
            else if (k < 10)
               send(2'd3, px, py, pz, $urandom);
            else if (k < 55)
               send(REQ_LOAD, px, py, pz, $urandom);
            else
               send(REQ_QUERY, px, py, pz, $urandom);
         end
         settle();
      end

      $display("covered %0d loads and %0d queries over %0d register settings",
               sb.loads, sb.queries, PHASES + 4);
      $display("including ties in the image fold, wide random positions and a long receiver stall");
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== cutoff_neighbor_counter.f =====
hw/rtl/cnc_pkg.sv
hw/rtl/cnc_channels.sv
hw/rtl/cnc_ram.sv
hw/rtl/cnc_div_cell.sv
hw/rtl/cnc_dist.sv
hw/rtl/cutoff_neighbor_counter.sv
tb/tb.sv
